### sv/es2c_pkg.sv
package es2c_pkg;

  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned SecsPerHour = 60 * 60;
  localparam int unsigned SecsPerDay  = SecsPerHour * 24;
  localparam int unsigned EpochYear   = 1970;

  // Day count since the epoch fits 16 bits (at most 49710).
  localparam int unsigned DayW = 16;
  // Seconds within a day fit 17 bits.
  localparam int unsigned SodW = 17;

  // Decoded time of day, as carried out of the last pipeline stage.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // Leap test for a year in 1970..2106; 2100 is the only century in range.
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'd0) && (y != 12'd2100);
  endfunction

  // Cumulative days before month m (0..12), normal or leap row.
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + ((leap && m >= 4'd2) ? 9'd1 : 9'd0);
  endfunction

  // Days from the epoch to January 1 of year offset k (0..136 from 1970).
  function automatic logic [DayW-1:0] year_start(input logic [7:0] k);
    logic [DayW-1:0] n;
    logic [DayW-1:0] leaps;
    n = {8'd0, k};
    // Leap years in 1970..1969+k: count multiples of 4 from 1972, drop 2100.
    leaps = (n + 16'd1) >> 2;
    if (k > 8'd130) leaps = leaps - 16'd1;
    return DayW'(n * 16'd365) + leaps;
  endfunction

endpackage

### sv/es2c_split.sv
// Stages 1 and 2: split seconds into day count and seconds within the day.
module es2c_split (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [31:0]                  secs_i,
  output logic                         valid_o,
  output logic [es2c_pkg::DayW-1:0]    days_o,
  output logic [es2c_pkg::SodW-1:0]    sod_o
);
  import es2c_pkg::*;

  logic            v1_q;
  logic [31:0]     secs1_q;
  logic [DayW-1:0] days1_q;
  logic [48:0]     prod;
  logic [DayW-1:0] dq;
  logic [SodW-1:0] sod;
  logic [SodW-1:0] sod_d;
  logic [DayW-1:0] days_d;

  // Reciprocal estimate of t / 86400 with floor(2^33 / 86400); may be one low.
  assign prod = 49'(secs_i) * 49'd99420;
  assign dq   = prod[48:33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      secs1_q <= secs_i;
      days1_q <= dq;
    end
  end

  // Correct the estimate when the remainder reaches a whole day.
  always_comb begin
    sod    = SodW'(secs1_q - 32'(days1_q) * 32'(SecsPerDay));
    days_d = days1_q;
    sod_d  = sod;
    if (sod >= SodW'(SecsPerDay)) begin
      sod_d  = sod - SodW'(SecsPerDay);
      days_d = days1_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days_o <= days_d;
      sod_o  <= sod_d;
    end
  end
endmodule

### sv/es2c_date.sv
// Stages 3 and 4: day count to year, then to month and day; seconds within
// the day to hour, then to minute and second.
module es2c_date (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [es2c_pkg::DayW-1:0] days_i,
  input  logic [es2c_pkg::SodW-1:0] sod_i,
  output logic                      valid_o,
  output logic [11:0]               year_o,
  output logic [3:0]                month_o,
  output logic [4:0]                day_o,
  output es2c_pkg::tod_t            tod_o
);
  import es2c_pkg::*;

  logic       v3_q;
  logic [7:0] k3_q;
  logic [8:0] doy3_q;
  logic [4:0] hr3_q;
  logic [11:0] remh3_q;
  logic [7:0] kg;
  logic [7:0] k;
  logic [DayW-1:0] ys;
  logic [DayW-1:0] ys_g;
  logic [DayW-1:0] ys_p;
  logic [33:0] hprod;
  logic [4:0]  hr;
  logic [11:0] rem_h;
  logic [24:0] mprod;
  logic [5:0]  mn;
  logic [11:0] y3;
  logic        leap3;
  logic [3:0]  m;
  logic [8:0]  dm;

  // Year guess days/365 (exact or one high), then step back once.
  always_comb begin
    kg   = 8'((32'(days_i) * 32'd45965) >> 24);
    ys_g = year_start(kg);
    ys_p = year_start(kg - 8'd1);
    k    = kg;
    ys   = ys_g;
    if (ys_g > days_i) begin
      k  = kg - 8'd1;
      ys = ys_p;
    end
  end

  // Hour by reciprocal multiply with ceil(2^28 / 3600), exact below 86400.
  always_comb begin
    hprod = 34'(sod_i) * 34'd74566;
    hr    = hprod[32:28];
    rem_h = 12'(sod_i - 17'(hr) * 17'(SecsPerHour));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k3_q    <= k;
      doy3_q  <= 9'(days_i - ys);
      hr3_q   <= hr;
      remh3_q <= rem_h;
    end
  end

  // Month search over the cumulative table, compares in parallel.
  always_comb begin
    y3    = 12'(EpochYear) + 12'(k3_q);
    leap3 = is_leap(y3);
    m     = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy3_q >= cum_days(leap3, 4'(i))) m = 4'(i);
    end
    dm = doy3_q - cum_days(leap3, m);
  end

  // Minute by reciprocal multiply with ceil(2^18 / 60), exact below 3600.
  always_comb begin
    mprod = 25'(remh3_q) * 25'd4370;
    mn    = mprod[23:18];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      year_o       <= y3;
      month_o      <= m + 4'd1;
      day_o        <= 5'(dm) + 5'd1;
      tod_o.hour   <= hr3_q;
      tod_o.minute <= mn;
      tod_o.second <= 6'(remh3_q - 12'(mn) * 12'(SecsPerMin));
    end
  end

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12)) else $error("month out of range");
  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (day_o >= 5'd1)) else $error("day zero");
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (year_o >= 12'd1970 && year_o <= 12'd2106)) else $error("year out of range");
endmodule

### sv/epoch_seconds_to_calendar.sv
// Converts unsigned 32-bit seconds since 1970-01-01 00:00:00 UTC into the
// Gregorian date and time of day. It is a four-stage pipeline that takes one
// beat per cycle while the output is not stalled; each beat passes through
// the split stages and then the date stages. A result held on a stalled
// output freezes the whole pipeline, so nothing is lost or repeated. The
// day split uses a reciprocal multiply, the year comes from a day-count
// estimate checked against the start of that year, and hour and minute
// are decoded by reciprocal multiplies alongside the date stages.
module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // year[11:0] month[15:12] day_of_month[20:16]
                                     // hour[25:21] minute[31:26] second[37:32]
);
  import es2c_pkg::*;

  logic            en;
  logic            v2;
  logic [DayW-1:0] days2;
  logic [SodW-1:0] sod2;
  tod_t            tod4;
  logic [11:0]     year;
  logic [3:0]      month;
  logic [4:0]      day;

  // Pipeline advances unless a held result is not taken.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  es2c_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .secs_i  (s_axis_tdata),
    .valid_o (v2),
    .days_o  (days2),
    .sod_o   (sod2)
  );

  es2c_date u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2),
    .days_i  (days2),
    .sod_i   (sod2),
    .valid_o (m_axis_tvalid),
    .year_o  (year),
    .month_o (month),
    .day_o   (day),
    .tod_o   (tod4)
  );

  assign m_axis_tdata = {2'b00, tod4.second, tod4.minute, tod4.hour, day, month, year};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("blocked while empty");
  a_tod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (tod4.hour < 5'd24 && tod4.minute < 6'd60 && tod4.second < 6'd60))
    else $error("time of day out of range");
endmodule
